// ===== hdl/dsl_pkg.sv =====
// Shared types and constants for the double-step line rasterizer.
package dsl_pkg;

	localparam int COORD_W        = 12;
	localparam int COLOR_W        = 32;
	localparam int DEF_COORD_BITS = 12;
	localparam int PIX_PER_STEP   = 4;
	localparam int CNT_W          = $clog2(PIX_PER_STEP + 1);
	localparam int IDX_W          = $clog2(PIX_PER_STEP);

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0] color;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_of_run;
		logic               line_done;
	} pixel_t;

	typedef struct packed {
		pixel_t [PIX_PER_STEP-1:0] pixels;
		logic [CNT_W-1:0]          count;
	} batch_t;

endpackage

// ===== hdl/double_step_line_rasterizer_top.sv =====
// Top level of the double-step line rasterizer: input register, line engine and pixel buffer.
//
// This block draws lines with the symmetric double-step algorithm. A load
// transfer (cmd CMD_LOAD) carries both endpoints and a color; it abandons any line in
// progress, sets up the new one and yields one pixel (both endpoints equal) or the two
// endpoint pixels. Each advance transfer (cmd CMD_ADVANCE) runs one double step and
// yields four pixels, two walking in from each end, or the final tail of one to three
// pixels; an advance with no line in progress yields nothing. A line of major length d
// gives d+1 pixels in all. The last pixel caused by an item has last_of_run set, and
// the pixel that completes the line also has line_done set. Coordinates are kept
// COORD_BITS wide and wrap at that width. An accepted item lands in an input register;
// in one pass the line engine works out its whole pixel batch and the next line state,
// and the batch moves into the pixel buffer as soon as the buffer is empty or sending
// its last pixel. The pixel port moves one pixel per transfer. An accepted item is
// registered in the input register and its batch then in the pixel buffer, from which
// its first pixel is offered. The item port can take one item into the input register
// while the buffer still drains a batch, and then stalls until that item's batch enters.
module double_step_line_rasterizer_top import dsl_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_ready,
	input  item_t  item,
	output logic   pixel_valid,
	input  logic   pixel_ready,
	output pixel_t pixel
);

	// Input register: holds one accepted item until the buffer can take its batch.
	item_t  item_s1;
	logic   valid_s1;
	logic   buf_ready;
	logic   take;
	batch_t batch;

	// The engine state advances exactly when a batch enters the buffer.
	assign take = valid_s1 && buf_ready;
	assign item_ready = !valid_s1 || buf_ready;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	dsl_engine #(
		.COORD_BITS(COORD_BITS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (take),
		.item  (item_s1),
		.batch (batch)
	);

	dsl_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (buf_ready),
		.batch      (batch),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel      (pixel)
	);

endmodule

// ===== hdl/dsl_engine.sv =====
// Line state registers and the single-pass logic that turns one item into a pixel batch.
module dsl_engine import dsl_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   step,
	input  item_t  item,
	output batch_t batch
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 6;

	typedef logic [CB-1:0] coord_t;
	typedef logic signed [DW-1:0] term_t;

	// Line state.
	coord_t           near_x_q, near_y_q, far_x_q, far_y_q;
	term_t            decision_q, incr_one_q, incr_two_q, threshold_q;
	logic             minor_neg_q, swapped_q, gentle_q, active_q;
	coord_t           iter_q;
	logic [1:0]       tail_q;
	logic [COLOR_W-1:0] color_q;

	coord_t           near_x_d, near_y_d, far_x_d, far_y_d;
	term_t            decision_d, incr_one_d, incr_two_d, threshold_d;
	logic             minor_neg_d, swapped_d, gentle_d, active_d;
	coord_t           iter_d;
	logic [1:0]       tail_d;
	logic [COLOR_W-1:0] color_d;

	// Load setup.
	coord_t     a1, b1, a2, b2;
	logic [CB:0] dxr, dyr, ndx, ndy;
	logic       neg_x, neg_y, swap;
	coord_t     adx, ady, dmaj, dmin, dm1;
	coord_t     ma1, mb1, ma2, mb2, ln_x, ln_y, lf_x, lf_y;
	term_t      dmj_s, dmn_s, it2, thr, it1, dec0;
	logic       gent;

	// Advance stepping.
	logic       case_a, case_b, case_c, diag_first;
	logic       m1, m2, mf1;
	coord_t     s_step, ny1, ny2, fy1, fy2;
	coord_t     nx1, nx2, fx1, fx2;

	coord_t [PIX_PER_STEP-1:0] px, py;
	logic [CNT_W-1:0]          cnt;
	logic                      done, out_swap;
	logic [COLOR_W-1:0]        out_color;

	always_comb begin
		a1 = CB'(item.start_x);
		b1 = CB'(item.start_y);
		a2 = CB'(item.end_x);
		b2 = CB'(item.end_y);
		dxr = {1'b0, a2} - {1'b0, a1};
		dyr = {1'b0, b2} - {1'b0, b1};
		ndx = -dxr;
		ndy = -dyr;
		neg_x = dxr[CB];
		neg_y = dyr[CB];
		adx = neg_x ? ndx[CB-1:0] : dxr[CB-1:0];
		ady = neg_y ? ndy[CB-1:0] : dyr[CB-1:0];
		swap = ady > adx;
		ma1 = swap ? b1 : a1;
		mb1 = swap ? a1 : b1;
		ma2 = swap ? b2 : a2;
		mb2 = swap ? a2 : b2;
		dmaj = swap ? ady : adx;
		dmin = swap ? adx : ady;
		dm1 = dmaj - CB'(1);
		if (ma1 > ma2) begin
			ln_x = ma2; ln_y = mb2; lf_x = ma1; lf_y = mb1;
		end else begin
			ln_x = ma1; ln_y = mb1; lf_x = ma2; lf_y = mb2;
		end
		dmj_s = $signed(DW'(dmaj));
		dmn_s = $signed(DW'(dmin));
		it2 = (dmn_s <<< 2) - (dmj_s <<< 1);
		gent = it2[DW-1];
		thr = gent ? (dmn_s <<< 1) : ((dmn_s - dmj_s) <<< 1);
		it1 = thr <<< 1;
		dec0 = gent ? (it1 - dmj_s) : (it1 + dmj_s);
	end

	always_comb begin
		case_a = gentle_q && decision_q[DW-1];
		case_b = !gentle_q && !decision_q[DW-1] && (|decision_q);
		case_c = decision_q < threshold_q;
		diag_first = case_a || case_b;
		s_step = minor_neg_q ? '1 : CB'(1);

		// Minor steps of the near walk (m1, m2) and of the first far pixel (mf1).
		if (iter_q != '0) begin
			if (case_a) begin
				m1 = 1'b0; m2 = 1'b0;
			end else if (case_b) begin
				m1 = 1'b1; m2 = 1'b1;
			end else if (case_c) begin
				m1 = 1'b0; m2 = 1'b1;
			end else begin
				m1 = 1'b1; m2 = 1'b0;
			end
			mf1 = m1;
		end else begin
			if (diag_first) begin
				m1 = !gentle_q; m2 = !gentle_q; mf1 = !gentle_q;
			end else if (case_c) begin
				m1 = 1'b0; m2 = 1'b1; mf1 = 1'b0;
			end else begin
				m1 = 1'b1; m2 = 1'b0;
				mf1 = gentle_q || (decision_q > threshold_q);
			end
		end

		nx1 = near_x_q + CB'(1);
		nx2 = near_x_q + CB'(2);
		fx1 = far_x_q - CB'(1);
		fx2 = far_x_q - CB'(2);
		ny1 = near_y_q + (m1 ? s_step : '0);
		ny2 = ny1 + (m2 ? s_step : '0);
		fy1 = far_y_q - (mf1 ? s_step : '0);
		fy2 = fy1 - (m2 ? s_step : '0);
	end

	always_comb begin
		near_x_d = near_x_q; near_y_d = near_y_q;
		far_x_d = far_x_q; far_y_d = far_y_q;
		decision_d = decision_q; incr_one_d = incr_one_q;
		incr_two_d = incr_two_q; threshold_d = threshold_q;
		minor_neg_d = minor_neg_q; swapped_d = swapped_q;
		gentle_d = gentle_q; active_d = active_q;
		iter_d = iter_q; tail_d = tail_q; color_d = color_q;

		px[0] = nx1; py[0] = ny1;
		px[1] = nx2; py[1] = ny2;
		px[2] = fx1; py[2] = fy1;
		px[3] = fx2; py[3] = fy2;
		cnt = '0;
		done = 1'b0;
		out_swap = swapped_q;
		out_color = color_q;

		if (item.cmd == CMD_LOAD) begin
			minor_neg_d = neg_x != neg_y;
			swapped_d = swap;
			color_d = item.color;
			near_x_d = ln_x; near_y_d = ln_y;
			far_x_d = lf_x; far_y_d = lf_y;
			out_swap = swap;
			out_color = item.color;
			px[0] = ln_x; py[0] = ln_y;
			px[1] = lf_x; py[1] = lf_y;
			if (dmaj == '0) begin
				// Both endpoints coincide: a single pixel finishes the line.
				cnt = CNT_W'(1);
				done = 1'b1;
				active_d = 1'b0;
				iter_d = '0;
				tail_d = '0;
			end else begin
				cnt = CNT_W'(2);
				iter_d = dm1 >> 2;
				tail_d = dm1[1:0];
				incr_two_d = it2;
				gentle_d = gent;
				threshold_d = thr;
				incr_one_d = it1;
				decision_d = dec0;
				done = dmaj == CB'(1);
				active_d = !done;
			end
		end else if (active_q) begin
			if (iter_q != '0) begin
				cnt = CNT_W'(PIX_PER_STEP);
				near_x_d = nx2; near_y_d = ny2;
				far_x_d = fx2; far_y_d = fy2;
				decision_d = decision_q + (diag_first ? incr_one_q : incr_two_q);
				iter_d = iter_q - CB'(1);
				done = (iter_q == CB'(1)) && (tail_q == '0);
				active_d = !done;
			end else if (tail_q != '0) begin
				cnt = CNT_W'(tail_q);
				done = 1'b1;
				active_d = 1'b0;
				tail_d = '0;
			end else begin
				active_d = 1'b0;
			end
		end
	end

	always_comb begin
		batch.count = cnt;
		for (int i = 0; i < PIX_PER_STEP; i++) begin
			batch.pixels[i].pixel_x = COORD_W'(out_swap ? py[i] : px[i]);
			batch.pixels[i].pixel_y = COORD_W'(out_swap ? px[i] : py[i]);
			batch.pixels[i].pixel_color = out_color;
			batch.pixels[i].last_of_run = (CNT_W'(i) + CNT_W'(1)) == cnt;
			batch.pixels[i].line_done = done && ((CNT_W'(i) + CNT_W'(1)) == cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_x_q <= '0; near_y_q <= '0; far_x_q <= '0; far_y_q <= '0;
			decision_q <= '0; incr_one_q <= '0; incr_two_q <= '0; threshold_q <= '0;
			minor_neg_q <= 1'b0; swapped_q <= 1'b0; gentle_q <= 1'b0;
			active_q <= 1'b0; iter_q <= '0; tail_q <= '0; color_q <= '0;
		end else if (step) begin
			near_x_q <= near_x_d; near_y_q <= near_y_d;
			far_x_q <= far_x_d; far_y_q <= far_y_d;
			decision_q <= decision_d; incr_one_q <= incr_one_d;
			incr_two_q <= incr_two_d; threshold_q <= threshold_d;
			minor_neg_q <= minor_neg_d; swapped_q <= swapped_d; gentle_q <= gentle_d;
			active_q <= active_d; iter_q <= iter_d; tail_q <= tail_d; color_q <= color_d;
		end
	end

`ifndef SYNTH
	a_idle_advance_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.cmd == CMD_ADVANCE && !active_q) |-> batch.count == '0)
		else $error("advance without an active line produced pixels");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.cmd == CMD_LOAD) |->
		(batch.count == CNT_W'(1) || batch.count == CNT_W'(2)))
		else $error("load produced a pixel count other than one or two");
`endif

endmodule

// ===== hdl/dsl_out_buf.sv =====
// Result buffer that holds one pixel batch and hands it out one pixel per transfer.
module dsl_out_buf import dsl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load_valid,
	output logic   load_ready,
	input  batch_t batch,
	output logic   pixel_valid,
	input  logic   pixel_ready,
	output pixel_t pixel
);

	pixel_t [PIX_PER_STEP-1:0] pixels_q;
	logic [CNT_W-1:0]          rem_q;
	logic [IDX_W-1:0]          rd_q;
	logic                      load;

	assign pixel_valid = rem_q != '0;
	assign pixel = pixels_q[rd_q];
	// Free once empty or while the last held pixel leaves.
	assign load_ready = (rem_q == '0) || ((rem_q == CNT_W'(1)) && pixel_ready);
	assign load = load_valid && load_ready;

	always_ff @(posedge clk) begin
		if (load) begin
			pixels_q <= batch.pixels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q <= '0;
		end else if (load) begin
			rem_q <= batch.count;
			rd_q <= '0;
		end else if (pixel_valid && pixel_ready) begin
			rem_q <= rem_q - CNT_W'(1);
			rd_q <= rd_q + IDX_W'(1);
		end
	end

`ifndef SYNTH
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && rem_q == CNT_W'(1)) |-> pixel.last_of_run)
		else $error("final pixel of a batch lacks last_of_run");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel.line_done) |-> pixel.last_of_run)
		else $error("line_done on a pixel that does not end its run");

	a_batch_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && batch.count != '0) |=> (pixel_valid && rd_q == '0))
		else $error("loaded batch did not start at its first pixel");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the double-step line rasterizer top level.
`timescale 1ns / 100ps

module tb;
	import dsl_pkg::*;

	// Largest coordinate on the 12-bit screen.
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	// The run stops if this many cycles pass with no transfer on either port.
	localparam int QUIET_LIMIT = 2000;
	// Cycles of watching for stray pixels once the last expected one has come.
	localparam int SETTLE_CYCLES = 20;
	// Length of the long receiver hold-off that forces the block to fill up.
	localparam int HOLD_CYCLES = 400;
	// Mismatches beyond this many are counted but not printed.
	localparam int REPORT_LIMIT = 10;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   item_valid = 1'b0;
	logic   item_ready;
	item_t  item_bus = '0;
	logic   pixel_valid;
	logic   pixel_ready = 1'b0;
	pixel_t pixel_bus;

	// Percent chance per cycle that the sender idles or the receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Set while the receiver is forced to hold off for a long stretch.
	bit receiver_hold = 1'b0;

	int error_count = 0;
	// Items that did real work, that is, every transfer but an advance with no line.
	int counted_items = 0;

	// Pixels still owed by the block, oldest first, and the batch of the item
	// being predicted.
	pixel_t expected_pixels[$];
	pixel_t run_pixels[$];

	// Line state of the predictor. Points are held in the frame where x is the
	// major axis; the swap is undone when a pixel is written out.
	int                 near_x, near_y, far_x, far_y;
	int                 decision, incr_one, incr_two, threshold;
	bit                 minor_neg, swapped, gentle;
	int                 steps_left, tail_left;
	bit                 line_live;
	logic [COLOR_W-1:0] line_color;

	double_step_line_rasterizer_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item_bus),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel      (pixel_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Queues one pixel of the current item. An item never yields more than a
	// full batch, so anything beyond that is dropped.
	function automatic void plot(int x, int y);
		pixel_t             p;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		if (run_pixels.size() < PIX_PER_STEP) begin
			px = x[COORD_W-1:0];
			py = y[COORD_W-1:0];
			p.pixel_x     = swapped ? py : px;
			p.pixel_y     = swapped ? px : py;
			p.pixel_color = line_color;
			p.last_of_run = 1'b0;
			p.line_done   = 1'b0;
			run_pixels.insert(run_pixels.size(), p);
		end
	endfunction

	// Flags the last pixel of the item and moves the batch to the expected store.
	function automatic void close_run(bit done);
		pixel_t p;
		if (run_pixels.size() > 0) begin
			p = run_pixels.pop_back();
			p.last_of_run = 1'b1;
			p.line_done   = done;
			run_pixels.insert(run_pixels.size(), p);
		end
		if (done)
			line_live = 1'b0;
		while (run_pixels.size() > 0)
			expected_pixels.insert(expected_pixels.size(), run_pixels.pop_front());
	endfunction

	function automatic void load_line(item_t it);
		int a1, b1, a2, b2, dx, dy, t;
		bit neg_x, neg_y;
		a1 = int'(it.start_x);
		b1 = int'(it.start_y);
		a2 = int'(it.end_x);
		b2 = int'(it.end_y);
		dx = a2 - a1;
		dy = b2 - b1;
		// A delta of zero counts as a positive direction.
		neg_x = dx < 0;
		neg_y = dy < 0;
		if (neg_x)
			dx = -dx;
		if (neg_y)
			dy = -dy;
		minor_neg  = neg_x != neg_y;
		line_color = it.color;
		swapped    = dy > dx;
		if (swapped) begin
			t = a1; a1 = b1; b1 = t;
			t = a2; a2 = b2; b2 = t;
			t = dx; dx = dy; dy = t;
		end
		if (a1 > a2) begin
			near_x = a2; near_y = b2; far_x = a1; far_y = b1;
		end else begin
			near_x = a1; near_y = b1; far_x = a2; far_y = b2;
		end
		line_live = 1'b1;
		plot(near_x, near_y);
		if (dx == 0) begin
			// Both endpoints coincide: one pixel and the line is over.
			steps_left = 0;
			tail_left  = 0;
			close_run(1'b1);
		end else begin
			steps_left = (dx - 1) / 4;
			tail_left  = (dx - 1) % 4;
			plot(far_x, far_y);
			incr_two = 4 * dy - 2 * dx;
			gentle   = incr_two < 0;
			if (gentle) begin
				threshold = 2 * dy;
				incr_one  = 2 * threshold;
				decision  = incr_one - dx;
			end else begin
				threshold = 2 * (dy - dx);
				incr_one  = 2 * threshold;
				decision  = incr_one + dx;
			end
			close_run(steps_left == 0 && tail_left == 0);
		end
	endfunction

	// One double step: two pixels inward from each end.
	function automatic void double_step();
		int s;
		s = minor_neg ? -1 : 1;
		near_x++;
		far_x--;
		if (gentle && decision < 0) begin
			plot(near_x, near_y);
			near_x++;
			plot(near_x, near_y);
			plot(far_x, far_y);
			far_x--;
			plot(far_x, far_y);
			decision += incr_one;
		end else if (!gentle && decision > 0) begin
			near_y += s;
			plot(near_x, near_y);
			near_x++; near_y += s;
			plot(near_x, near_y);
			far_y -= s;
			plot(far_x, far_y);
			far_x--; far_y -= s;
			plot(far_x, far_y);
			decision += incr_one;
		end else if (decision < threshold) begin
			plot(near_x, near_y);
			near_x++; near_y += s;
			plot(near_x, near_y);
			plot(far_x, far_y);
			far_x--; far_y -= s;
			plot(far_x, far_y);
			decision += incr_two;
		end else begin
			near_y += s;
			plot(near_x, near_y);
			near_x++;
			plot(near_x, near_y);
			far_y -= s;
			plot(far_x, far_y);
			far_x--;
			plot(far_x, far_y);
			decision += incr_two;
		end
		steps_left--;
		close_run(steps_left == 0 && tail_left == 0);
	endfunction

	// Final one to three pixels of the line.
	function automatic void draw_tail();
		int s, m;
		s = minor_neg ? -1 : 1;
		if ((gentle && decision < 0) || (!gentle && decision > 0)) begin
			m = gentle ? 0 : s;
			near_x++; near_y += m;
			plot(near_x, near_y);
			if (tail_left > 1) begin
				near_x++; near_y += m;
				plot(near_x, near_y);
			end
			if (tail_left > 2) begin
				far_x--; far_y -= m;
				plot(far_x, far_y);
			end
		end else if (decision < threshold) begin
			near_x++;
			plot(near_x, near_y);
			if (tail_left > 1) begin
				near_x++; near_y += s;
				plot(near_x, near_y);
			end
			if (tail_left > 2) begin
				far_x--;
				plot(far_x, far_y);
			end
		end else begin
			near_x++; near_y += s;
			plot(near_x, near_y);
			if (tail_left > 1) begin
				near_x++;
				plot(near_x, near_y);
			end
			if (tail_left > 2) begin
				far_x--;
				if (gentle || decision > threshold)
					far_y -= s;
				plot(far_x, far_y);
			end
		end
		tail_left = 0;
		close_run(1'b1);
	endfunction

	// Works out the pixels one accepted item causes and advances the line state.
	function automatic void rasterize(item_t it);
		if (it.cmd == CMD_LOAD) begin
			load_line(it);
		end else if (line_live) begin
			if (steps_left > 0)
				double_step();
			else if (tail_left > 0)
				draw_tail();
			else
				line_live = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Item side
	// ------------------------------------------------------------------

	// Offers one item, holds it until the transfer, then predicts its pixels.
	// Valid stays high after the transfer so that back-to-back items run with
	// no gap; it only drops when the sender idles or drains.
	task automatic send_item(item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		item_bus   <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		if (it.cmd == CMD_LOAD || line_live)
			counted_items++;
		rasterize(it);
	endtask

	// Stops offering items until every predicted pixel has been taken. It always
	// waits on the clock first, so valid is never dropped and raised in the same step.
	task automatic wait_pixels_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_pixels.size() != 0);
	endtask

	function automatic item_t line_item(int sx, int sy, int ex, int ey, logic [31:0] color);
		item_t it;
		it.cmd     = CMD_LOAD;
		it.start_x = sx[COORD_W-1:0];
		it.start_y = sy[COORD_W-1:0];
		it.end_x   = ex[COORD_W-1:0];
		it.end_y   = ey[COORD_W-1:0];
		it.color   = color;
		return it;
	endfunction

	// An advance carries random junk in the fields it does not use.
	function automatic item_t advance_item();
		item_t       it;
		logic [31:0] r1;
		logic [31:0] r2;
		r1 = $urandom();
		r2 = $urandom();
		it = line_item(int'(r1[11:0]), int'(r1[23:12]), int'(r2[11:0]), int'(r2[23:12]),
			$urandom());
		it.cmd = CMD_ADVANCE;
		return it;
	endfunction

	task automatic send_advances(int count);
		repeat (count)
			send_item(advance_item());
	endtask

	// A coordinate within span of c, kept on the screen.
	function automatic logic [COORD_W-1:0] offset_coord(int c, int span);
		int v;
		v = c + int'($urandom_range(2 * span)) - span;
		if (v < 0)
			v = 0;
		else if (v > COORD_MAX)
			v = COORD_MAX;
		return v[COORD_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Pixel side: random ready, and each pixel checked against the oldest
	// prediction.
	// ------------------------------------------------------------------

	function automatic void check_pixel(pixel_t got);
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("[%0t] pixel with none expected: x=%0d y=%0d color=%h last=%b done=%b",
					$realtime, got.pixel_x, got.pixel_y, got.pixel_color,
					got.last_of_run, got.line_done);
		end else begin
			want = expected_pixels.pop_front();
			if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y
					|| got.pixel_color !== want.pixel_color
					|| got.last_of_run !== want.last_of_run
					|| got.line_done !== want.line_done) begin
				error_count++;
				if (error_count <= REPORT_LIMIT) begin
					$display("[%0t] pixel mismatch", $realtime);
					$display("  expected x=%0d y=%0d color=%h last=%b done=%b",
						want.pixel_x, want.pixel_y, want.pixel_color,
						want.last_of_run, want.line_done);
					$display("  actual   x=%0d y=%0d color=%h last=%b done=%b",
						got.pixel_x, got.pixel_y, got.pixel_color,
						got.last_of_run, got.line_done);
				end
			end
		end
	endfunction

	// Outputs are read right after the edge, before any register of the block
	// has been updated, so they hold the values the edge itself sampled.
	always @(posedge clk) begin
		if (arst_n && pixel_valid && pixel_ready)
			check_pixel(pixel_bus);
		pixel_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: a run that makes no progress for too long has hung.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (pixel_valid && pixel_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Nothing has been loaded yet, so an advance must give no pixel.
	task automatic test_advance_without_line();
		send_advances(1);
		wait_pixels_drained();
	endtask

	// Coinciding endpoints at both screen corners, with the extreme colors.
	task automatic test_single_points();
		send_item(line_item(0, 0, 0, 0, 32'h0000_0000));
		send_item(line_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF));
		wait_pixels_drained();
	endtask

	// Major length one: the load alone finishes the line.
	task automatic test_short_lines();
		send_item(line_item(COORD_MAX, 0, COORD_MAX - 1, 1, 32'h5A5A_A5A5));
		send_item(line_item(0, COORD_MAX, 1, COORD_MAX, 32'hA5A5_5A5A));
		wait_pixels_drained();
	endtask

	// A gentle slope, a steep one with both deltas negative, and a
	// diagonal, each drawn to the end.
	task automatic test_sloped_lines();
		send_item(line_item(0, 0, 10, 3, 32'h1234_5678));
		send_advances(3);
		send_item(line_item(100, COORD_MAX, 97, COORD_MAX - 10, 32'h8765_4321));
		send_advances(3);
		send_item(line_item(0, COORD_MAX, 5, COORD_MAX - 5, 32'hC0FF_EE00));
		send_advances(1);
		wait_pixels_drained();
	endtask

	// Horizontal line drawn right to left, and a vertical one, where a zero
	// delta has to count as a positive direction.
	task automatic test_axis_aligned();
		send_item(line_item(COORD_MAX, 7, COORD_MAX - 7, 7, 32'h0F0F_0F0F));
		send_advances(2);
		send_item(line_item(3, 0, 3, 8, 32'hF0F0_F0F0));
		send_advances(2);
		wait_pixels_drained();
	endtask

	// A new load drops the line in progress; an advance after the end of a
	// line gives nothing.
	task automatic test_load_abandons_line();
		send_item(line_item(0, 0, COORD_MAX, COORD_MAX, 32'hDEAD_BEEF));
		send_advances(1);
		send_item(line_item(2000, 1000, 2003, 1002, 32'h0BAD_F00D));
		send_advances(2);
		wait_pixels_drained();
	endtask

	// Loads a random line and mostly draws it to the end. Now and then the
	// line is dropped early, and sometimes an advance follows the finished line.
	task automatic random_line();
		item_t       it;
		int          sx, sy, span, shape;
		logic [31:0] r;
		r     = $urandom();
		sx    = int'(r[11:0]);
		sy    = int'(r[23:12]);
		shape = $urandom_range(9);
		span  = ($urandom_range(9) == 0) ? 400 : 24;
		it    = line_item(sx, sy, sx, sy, $urandom());
		case (shape)
			0: ;
			1: it.end_x = offset_coord(sx, span);
			2: it.end_y = offset_coord(sy, span);
			3: begin
				r = $urandom();
				it.end_x = r[11:0];
				it.end_y = r[23:12];
			end
			default: begin
				it.end_x = offset_coord(sx, span);
				it.end_y = offset_coord(sy, span);
			end
		endcase
		send_item(it);
		while (line_live && $urandom_range(29) != 0)
			send_item(advance_item());
		if ($urandom_range(4) == 0)
			send_item(advance_item());
	endtask

	task automatic test_random_lines(int item_count, int idle_pct, int stall_pct);
		int target;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target = counted_items + item_count;
		while (counted_items < target)
			random_line();
		wait_pixels_drained();
	endtask

	// The receiver holds off for a long stretch while the sender keeps going,
	// so the pixel buffer fills and the item port has to stall. Afterwards the
	// sender pauses until every pixel has come.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fork
			begin
				receiver_hold = 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				receiver_hold = 1'b0;
			end
			begin
				send_item(line_item(0, 0, COORD_MAX, 1000, 32'h7777_1111));
				send_advances(40);
			end
		join
		wait_pixels_drained();
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_advance_without_line();
		test_single_points();
		test_short_lines();
		test_sloped_lines();
		test_axis_aligned();
		test_load_abandons_line();

		test_random_lines(100, 0, 0);
		test_random_lines(100, 80, 0);
		test_random_lines(100, 0, 80);
		test_random_lines(100, 15, 15);
		test_backpressure();

		// Keep taking pixels for a while to catch any the block still sends.
		recv_stall_pct = 0;
		wait_pixels_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (error_count == 0 && expected_pixels.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
